// File: hdl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg - shared definitions for the mandelbrot escape-time block
// fixed-point widths, register map, config and point structs, saturation
// helpers for signed q4.28 coordinates
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int COORD_W = 32;                 // signed coordinate width
    localparam int FRAC_W  = 28;                 // fraction bits
    localparam int CNT_W   = 16;                 // iteration count width
    localparam int POS_W   = 12;                 // pixel column / row width
    localparam int STEP_W  = COORD_W - 1;        // unsigned step and radius width
    localparam int OFS_W   = POS_W + STEP_W;     // pixel offset product width
    localparam int PROD_W  = 2 * COORD_W;        // full coordinate product width
    localparam int WIDE_W  = 2 * COORD_W + 2;    // headroom for sums before saturation
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;                  // five registers at 4-byte spacing
    localparam int IDX_W   = APB_AW - 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // register map, index = byte address / 4
    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_PIXEL_STEP = 3'd2,
        REG_ITER_LIMIT = 3'd3,
        REG_ESCAPE_RSQ = 3'd4
    } reg_idx_t;

    // reset values: origin (-2.0, 1.0), step 2^-8, limit 256, radius squared 4.0
    localparam coord_t              RST_ORIGIN_X   = 32'hE000_0000;
    localparam coord_t              RST_ORIGIN_Y   = 32'h1000_0000;
    localparam logic [STEP_W-1:0]   RST_PIXEL_STEP = 31'h0010_0000;
    localparam logic [CNT_W-1:0]    RST_ITER_LIMIT = 16'd256;
    localparam logic [STEP_W-1:0]   RST_ESCAPE_RSQ = 31'h4000_0000;

    typedef struct packed {
        coord_t              origin_x;
        coord_t              origin_y;
        logic [STEP_W-1:0]   pixel_step;
        logic [CNT_W-1:0]    iteration_limit;
        logic [STEP_W-1:0]   escape_radius_sq;
    } cfg_t;

    typedef struct packed {
        coord_t c_real;
        coord_t c_imag;
    } point_t;

    function automatic wide_t widen(input coord_t a);
        return WIDE_W'(a);
    endfunction

    // true when the value does not fit the signed coordinate range
    function automatic logic coord_ovf(input wide_t v);
        return !((&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1]));
    endfunction

    function automatic coord_t coord_sat(input wide_t v);
        coord_t r;
        if (coord_ovf(v))
        begin
            r = v[WIDE_W-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/mbe_if.sv
// ----------------------------------------------------------------------------
// mbe_if - valid/ready channels of the escape-time block
// pixel channel carries (col, row), result channel carries count and flag
// ----------------------------------------------------------------------------
interface mbe_pix_if;
    import mbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;

    modport source (output valid, col, row, input ready);
    modport sink   (input valid, col, row, output ready);
endinterface

interface mbe_res_if;
    import mbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] iteration_count;
    logic             escaped;

    modport source (output valid, iteration_count, escaped, input ready);
    modport sink   (input valid, iteration_count, escaped, output ready);
endinterface

// File: hdl/mbe_regs.sv
// ----------------------------------------------------------------------------
// mbe_regs - apb configuration registers
// write in the access phase, zero-wait reads, unknown indexes ignored
// ----------------------------------------------------------------------------
module mbe_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::APB_AW-1:0]  paddr,
    input  logic [mbe_pkg::APB_DW-1:0]  pwdata,
    output logic [mbe_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output mbe_pkg::cfg_t               cfg
);
    import mbe_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x         <= RST_ORIGIN_X;
            cfg_reg.origin_y         <= RST_ORIGIN_Y;
            cfg_reg.pixel_step       <= RST_PIXEL_STEP;
            cfg_reg.iteration_limit  <= RST_ITER_LIMIT;
            cfg_reg.escape_radius_sq <= RST_ESCAPE_RSQ;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ORIGIN_X:   cfg_reg.origin_x         <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:   cfg_reg.origin_y         <= pwdata[COORD_W-1:0];
                REG_PIXEL_STEP: cfg_reg.pixel_step       <= pwdata[STEP_W-1:0];
                REG_ITER_LIMIT: cfg_reg.iteration_limit  <= pwdata[CNT_W-1:0];
                REG_ESCAPE_RSQ: cfg_reg.escape_radius_sq <= pwdata[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ORIGIN_X:   prdata = APB_DW'($unsigned(cfg_reg.origin_x));
            REG_ORIGIN_Y:   prdata = APB_DW'($unsigned(cfg_reg.origin_y));
            REG_PIXEL_STEP: prdata = APB_DW'(cfg_reg.pixel_step);
            REG_ITER_LIMIT: prdata = APB_DW'(cfg_reg.iteration_limit);
            REG_ESCAPE_RSQ: prdata = APB_DW'(cfg_reg.escape_radius_sq);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: hdl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front - pixel intake and point formation
// multiplies col and row by the step, then adds to the origin with saturation
// ----------------------------------------------------------------------------
module mbe_front
(
    input  logic             clk,
    input  logic             rst_n,
    mbe_pix_if.sink          pixel,
    input  mbe_pkg::cfg_t    cfg,
    output mbe_pkg::point_t  point,
    output logic             point_valid,
    input  logic             point_ready
);
    import mbe_pkg::*;

    logic             ofs_valid_reg;
    logic [OFS_W-1:0] col_ofs_reg;
    logic [OFS_W-1:0] row_ofs_reg;
    logic [OFS_W-1:0] col_ofs_next;
    logic [OFS_W-1:0] row_ofs_next;
    logic             take;

    assign pixel.ready  = !ofs_valid_reg || point_ready;
    assign take         = pixel.valid && pixel.ready;
    assign col_ofs_next = OFS_W'(pixel.col) * OFS_W'(cfg.pixel_step);
    assign row_ofs_next = OFS_W'(pixel.row) * OFS_W'(cfg.pixel_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            ofs_valid_reg <= 1'b1;
        end
        else if (point_ready)
        begin
            ofs_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_ofs_reg <= col_ofs_next;
            row_ofs_reg <= row_ofs_next;
        end
    end

    // rows count downward, so the imaginary part falls with row
    assign point.c_real = coord_sat(widen(cfg.origin_x) + $signed(WIDE_W'(col_ofs_reg)));
    assign point.c_imag = coord_sat(widen(cfg.origin_y) - $signed(WIDE_W'(row_ofs_reg)));
    assign point_valid  = ofs_valid_reg;

endmodule

// File: hdl/mbe_fifo.sv
// ----------------------------------------------------------------------------
// mbe_fifo - two-entry point queue
// decouples point formation from the iteration engine
// ----------------------------------------------------------------------------
module mbe_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  mbe_pkg::point_t  push_data,
    input  logic             push_valid,
    output logic             push_ready,
    output mbe_pkg::point_t  pop_data,
    output logic             pop_valid,
    input  logic             pop_ready
);
    import mbe_pkg::*;

    point_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/mbe_core.sv
// ----------------------------------------------------------------------------
// mbe_core - escape-time iteration engine
// one complex square and escape test per cycle, registered result beat
// ----------------------------------------------------------------------------
module mbe_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  mbe_pkg::cfg_t    cfg,
    input  mbe_pkg::point_t  point,
    input  logic             point_valid,
    output logic             point_ready,
    mbe_res_if.source        result
);
    import mbe_pkg::*;

    logic              busy_reg;
    coord_t            zr_reg;
    coord_t            zi_reg;
    coord_t            cr_reg;
    coord_t            ci_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              res_valid_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic              res_escaped_reg;

    logic signed [PROD_W-1:0] prod_rr;
    logic signed [PROD_W-1:0] prod_ii;
    logic signed [PROD_W-1:0] prod_ri;
    wide_t  sq_r_w;
    wide_t  sq_i_w;
    wide_t  cross_w;
    wide_t  r2_w;
    coord_t xx;
    coord_t yy;
    coord_t xy;
    coord_t diff;
    coord_t dbl;
    coord_t r2;
    coord_t zr_next;
    coord_t zi_next;
    logic   sq_ovf;
    logic   esc_hit;
    logic   lim_hit;
    logic   done;
    logic   slot_free;

    // products of the current iterate; the squares serve both the escape
    // test of this iterate and the next step
    assign prod_rr = zr_reg * zr_reg;
    assign prod_ii = zi_reg * zi_reg;
    assign prod_ri = zr_reg * zi_reg;
    assign sq_r_w  = WIDE_W'(prod_rr >>> FRAC_W);
    assign sq_i_w  = WIDE_W'(prod_ii >>> FRAC_W);
    assign cross_w = WIDE_W'(prod_ri >>> FRAC_W);
    assign xx      = coord_sat(sq_r_w);
    assign yy      = coord_sat(sq_i_w);
    assign xy      = coord_sat(cross_w);

    assign diff    = coord_sat(widen(xx) - widen(yy));
    assign zr_next = coord_sat(widen(diff) + widen(cr_reg));
    assign dbl     = coord_sat(widen(xy) + widen(xy));
    assign zi_next = coord_sat(widen(dbl) + widen(ci_reg));

    assign r2_w    = widen(xx) + widen(yy);
    assign r2      = coord_sat(r2_w);
    assign sq_ovf  = coord_ovf(sq_r_w) || coord_ovf(sq_i_w) || coord_ovf(r2_w);

    assign esc_hit = sq_ovf || ($signed({1'b0, cfg.escape_radius_sq}) < r2);
    assign lim_hit = (count_reg >= cfg.iteration_limit) || (count_reg == CNT_MAX);
    assign done    = esc_hit || lim_hit;

    assign slot_free   = !res_valid_reg || result.ready;
    assign point_ready = !busy_reg;

    assign result.valid           = res_valid_reg;
    assign result.iteration_count = res_count_reg;
    assign result.escaped         = res_escaped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= CNT_ONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result beat may replace the one taken on this edge
            if (busy_reg && done && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (!busy_reg)
            begin
                if (point_valid)
                begin
                    busy_reg  <= 1'b1;
                    count_reg <= CNT_ONE;
                end
            end
            else if (done)
            begin
                // hold the finished iterate until the result slot frees up
                if (slot_free)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                count_reg <= count_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (point_valid)
            begin
                // first step from z = 0 lands exactly on c
                zr_reg <= point.c_real;
                zi_reg <= point.c_imag;
                cr_reg <= point.c_real;
                ci_reg <= point.c_imag;
            end
        end
        else if (done)
        begin
            if (slot_free)
            begin
                res_count_reg   <= count_reg;
                res_escaped_reg <= esc_hit;
            end
        end
        else
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
    end

`ifndef SYNTHESIS
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(busy_reg))
        else $error("result beat raised without an item in flight");

    a_count_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && $past(busy_reg) |->
            (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_ONE))
        else $error("iteration count jumped");

    a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg <= cfg.iteration_limit) || (count_reg == CNT_ONE))
        else $error("iteration count passed the limit");

    a_inside_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_escaped_reg |->
            (res_count_reg >= cfg.iteration_limit) || (res_count_reg == CNT_MAX))
        else $error("non-escaped result below the iteration limit");
`endif

endmodule

// File: hdl/mandelbrot_escape_time_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top - escape-time counter for one pixel per beat
// apb configuration, pixel beats in, iteration count and escape flag out
// ----------------------------------------------------------------------------
// Each pixel beat (col, row) becomes the point c = (origin_x + col*step,
// origin_y - row*step) in signed q4.28, and z = z*z + c is iterated from zero
// until |z|^2 exceeds escape_radius_sq (or a square overflows) or the count
// reaches iteration_limit. The iteration engine takes one pixel at a time: a
// load step, then one complex square and escape test per iteration, so the
// engine's iteration loop sets the rate (the default limit is 256 iterations).
// Point formation runs ahead in the front end and up to two formed points
// wait in a queue, so a new pixel beat is normally taken while the engine is
// still busy; the result sits in an output register and the engine stops
// only when that register is still full. Configuration is meant to change
// only while no pixel is in flight.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::APB_AW-1:0]  paddr,
    input  logic [mbe_pkg::APB_DW-1:0]  pwdata,
    output logic [mbe_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    mbe_pix_if.sink                     pixel,
    mbe_res_if.source                   result
);
    import mbe_pkg::*;

    cfg_t   cfg;            // live register values
    point_t front_point;    // formed point leaving the front end
    logic   front_valid;
    logic   front_ready;
    point_t queue_point;    // point at the head of the queue
    logic   queue_valid;
    logic   queue_ready;

    // configuration registers
    mbe_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end: takes pixel beats and forms the complex point
    mbe_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .cfg         (cfg),
        .point       (front_point),
        .point_valid (front_valid),
        .point_ready (front_ready)
    );

    // short queue so the front end keeps taking beats while the engine iterates
    mbe_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_point),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (queue_point),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    // back end: iteration engine with registered result beat
    mbe_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .point       (queue_point),
        .point_valid (queue_valid),
        .point_ready (queue_ready),
        .result      (result)
    );

endmodule
